// ----- hdl/sti_pkg.sv -----
`default_nettype none

package sti_pkg;

   localparam int STI_MAX_TERMS = 16;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_SCALE = 2'd2,
      CMD_READ  = 2'd3
   } sti_cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_BAD_INDEX = 2'd2
   } sti_status_type;

   // what one cell hands to its right-hand neighbour
   typedef struct packed {
      logic       below;   // held entry is occupied and smaller than the new magnitude
      logic [7:0] value;
   } sti_link_type;

endpackage

`default_nettype wire

// ----- hdl/sti_req_if.sv -----
`default_nettype none

interface sti_req_if
   import sti_pkg::*;
();
   logic              valid;
   logic              ready;
   sti_cmd_type       command;
   logic signed [7:0] item_value;
   logic signed [7:0] scale_factor;
   logic [3:0]        read_index;

   modport source (output valid, command, item_value, scale_factor, read_index,
                   input ready);
   modport sink   (input valid, command, item_value, scale_factor, read_index,
                   output ready);
endinterface

`default_nettype wire

// ----- hdl/sti_rsp_if.sv -----
`default_nettype none

interface sti_rsp_if
   import sti_pkg::*;
();
   logic              valid;
   logic              ready;
   logic signed [7:0] multiplier;
   logic [3:0]        entry_count;
   logic [15:0]       magnitude_sum;
   logic [7:0]        read_value;
   sti_status_type    status;

   modport source (output valid, multiplier, entry_count, magnitude_sum, read_value,
                   status, input ready);
   modport sink   (input valid, multiplier, entry_count, magnitude_sum, read_value,
                   status, output ready);
endinterface

`default_nettype wire

// ----- hdl/sti_cell.sv -----
`default_nettype none

module sti_cell
   import sti_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         insert_en,
   input  wire logic         occupied,
   input  wire logic [7:0]   new_mag,
   input  wire sti_link_type left_link,
   output sti_link_type      right_link,
   output logic [7:0]        value
);

   logic [7:0] entry_ff;
   logic [7:0] entry_in;
   logic       below;

   assign below = occupied && (entry_ff < new_mag);

   // keep if smaller, take the new magnitude at the boundary, else shift from the left
   always_comb begin
      if (below) begin
         entry_in = entry_ff;
      end else if (left_link.below) begin
         entry_in = new_mag;
      end else begin
         entry_in = left_link.value;
      end
   end

   always_ff @(posedge clock) begin
      if (insert_en) begin
         entry_ff <= entry_in;
      end
   end

   assign right_link.below = below;
   assign right_link.value = entry_ff;
   assign value            = entry_ff;

endmodule

`default_nettype wire

// ----- hdl/sorted_term_insert.sv -----
// channel   dir  handshake      payload
// req_port  in   valid/ready    command, item_value, scale_factor, read_index
// rsp_port  out  valid/ready    multiplier, entry_count, magnitude_sum, read_value, status
//
// one command per cycle: every cell of the row decides its own shift in parallel
// the result sits in an output register; a new command is taken whenever that
// register is empty or being emptied in the same cycle
// a stalled response holds the request side, nothing is lost
// the entry store needs no clearing on reset since only held
// positions are ever read
`default_nettype none

module sorted_term_insert
   import sti_pkg::*;
#(
   parameter int MAX_TERMS = STI_MAX_TERMS
)(
   input  wire logic clock,
   input  wire logic reset,
   sti_req_if.sink   req_port,
   sti_rsp_if.source rsp_port
);

   localparam int CW    = $clog2(MAX_TERMS);
   localparam int DEPTH = MAX_TERMS - 1;
   localparam int NREAD = (DEPTH < 16) ? DEPTH : 16;
   localparam int EW    = CW + 4;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [CW-1:0]  count_ff,  count_in;
   logic [7:0]     mult_ff,   mult_in;
   logic [15:0]    sum_ff,    sum_in;
   logic           rsp_valid_ff;
   logic [7:0]     rsp_mult_ff;
   logic [3:0]     rsp_count_ff;
   logic [15:0]    rsp_sum_ff;
   logic [7:0]     rsp_read_ff,  rsp_read_in;
   sti_status_type rsp_status_ff, rsp_status_in;

   logic           accept;
   logic           full;
   logic           negative;
   logic [7:0]     item_raw;
   logic [7:0]     new_mag;
   logic [7:0]     add_mult;
   logic [7:0]     scale_mult;
   logic           insert_en;
   logic           index_ok;
   logic [EW-1:0]  count_ext;
   logic [EW-1:0]  index_ext;
   logic [EW-1:0]  count_in_ext;
   logic [7:0]     picked;

   sti_link_type   links [DEPTH+1];
   logic [7:0]     values [DEPTH];
   logic           occupied [DEPTH];

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;

   assign full      = (count_ff == FULL_COUNT);
   assign item_raw  = req_port.item_value;
   assign negative  = item_raw[7];
   // magnitude of -128 wraps back onto 0x80, which reads as 128 unsigned
   assign new_mag   = negative ? (8'd0 - item_raw) : item_raw;
   assign insert_en = accept && (req_port.command == CMD_ADD) && !full;

   always_comb begin
      logic [7:0] m;
      m = (mult_ff == 8'd0) ? 8'd1 : mult_ff;
      if (negative) begin
         m = 8'd0 - m;
      end
      if (item_raw == 8'd0) begin
         m = 8'd0;
      end
      add_mult = m;
   end

   assign scale_mult = 8'(mult_ff * 8'(req_port.scale_factor));

   // cell row
   assign links[0].below = 1'b1;
   assign links[0].value = new_mag;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign occupied[i] = (CW'(i) < count_ff);
      sti_cell u_cell (
         .clock      (clock),
         .insert_en  (insert_en),
         .occupied   (occupied[i]),
         .new_mag    (new_mag),
         .left_link  (links[i]),
         .right_link (links[i+1]),
         .value      (values[i])
      );
   end

   // read port over at most the first sixteen positions
   assign count_ext = {4'd0, count_ff};
   assign index_ext = EW'(req_port.read_index);
   assign index_ok  = index_ext < count_ext;

   always_comb begin
      picked = 8'd0;
      for (int i = 0; i < NREAD; i++) begin
         if (req_port.read_index == 4'(i)) begin
            picked = values[i];
         end
      end
   end

   always_comb begin
      count_in      = count_ff;
      mult_in       = mult_ff;
      sum_in        = sum_ff;
      rsp_read_in   = 8'd0;
      rsp_status_in = ST_OK;
      case (req_port.command)
         CMD_CLEAR: begin
            count_in = '0;
            mult_in  = 8'd0;
            sum_in   = 16'd0;
         end
         CMD_ADD: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               count_in = count_ff + CW'(1);
               mult_in  = add_mult;
               sum_in   = sum_ff + 16'(new_mag);
            end
         end
         CMD_SCALE: begin
            mult_in = scale_mult;
         end
         CMD_READ: begin
            if (index_ok) begin
               rsp_read_in = picked;
            end else begin
               rsp_status_in = ST_BAD_INDEX;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   assign count_in_ext = {4'd0, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mult_ff      <= 8'd0;
         sum_ff       <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            mult_ff      <= mult_in;
            sum_ff       <= sum_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_mult_ff   <= mult_in;
         rsp_count_ff  <= count_in_ext[3:0];
         rsp_sum_ff    <= sum_in;
         rsp_read_ff   <= rsp_read_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.multiplier    = rsp_mult_ff;
   assign rsp_port.entry_count   = rsp_count_ff;
   assign rsp_port.magnitude_sum = rsp_sum_ff;
   assign rsp_port.read_value    = rsp_read_ff;
   assign rsp_port.status        = rsp_status_ff;

endmodule

`default_nettype wire
